// ----- src/rls_pkg.sv -----
// Shared types and constants for the rain/light sensor wiper mode unit.
// Used by rls_light_enc, rls_wiper_ctrl and rain_light_sensor_wiper_mode_unit.
// No dependencies.
package rls_pkg;

  // Number of auto wiper sensitivity steps; the threshold is clamped to one less.
  localparam int THRESHOLD_MODES = 4;
  localparam int THR_W = (THRESHOLD_MODES > 1) ? $clog2(THRESHOLD_MODES) : 1;
  localparam logic [7:0] THR_MAX = 8'(THRESHOLD_MODES - 1);

  // Transaction kinds on the input channel.
  localparam logic CMD_DEMAND = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_AUTO_LEVER = 2'd0;
  localparam logic [1:0] REG_IGN_ON     = 2'd1;
  localparam logic [1:0] REG_IGN_OFF    = 2'd2;

  // Configuration reset values.
  localparam logic [7:0] AUTO_LEVER_RST = 8'd2;
  localparam logic [7:0] IGN_ON_RST     = 8'd1;
  localparam logic [7:0] IGN_OFF_RST    = 8'd0;
  localparam logic [7:0] LEVER_OFF_CODE = 8'd0;

  // Demand thresholds in percent.
  localparam logic [6:0] PCT_MAX     = 7'd100;
  localparam logic [6:0] PCT_FAST    = 7'd80;
  localparam logic [6:0] PCT_SLOW    = 7'd40;
  localparam logic [6:0] PCT_INT_MIN = 7'd5;

  // Interval wipe timing in milliseconds.
  localparam logic [12:0] INTERVAL_BASE = 13'd8000;
  localparam logic [6:0]  INTERVAL_STEP = 7'd100;
  localparam logic [31:0] ONCE_WINDOW   = 32'd500;

  // Light level range limits.
  localparam logic [31:0] LVL_SAT  = 32'd127000;
  localparam logic [31:0] LVL_EXP3 = 32'd12700;
  localparam logic [31:0] LVL_EXP2 = 32'd1270;
  localparam logic [31:0] LVL_EXP1 = 32'd127;
  localparam logic [6:0]  MANT_SAT = 7'd127;

  // Reciprocal multipliers, exact over the range each divisor sees.
  localparam logic [17:0] DIV1000_MUL = 18'd134218;
  localparam int          DIV1000_SH  = 27;
  localparam logic [13:0] DIV100_MUL  = 14'd10486;
  localparam int          DIV100_SH   = 20;
  localparam logic [10:0] DIV10_MUL   = 11'd1639;
  localparam int          DIV10_SH    = 14;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_ONCE = 2'd1,
    MODE_SLOW = 2'd2,
    MODE_FAST = 2'd3
  } wmode_t;

  typedef enum logic [1:0] {
    DARK_OFF      = 2'd0,
    DARK_LIGHTS   = 2'd2,
    DARK_TOO_DARK = 2'd3
  } dark_t;

  typedef struct packed {
    logic              cmd;
    logic signed [7:0] wipe_percent;
    logic [31:0]       time_ms;
    logic [31:0]       ambient_level;
    logic              rain_close_in;
    logic [7:0]        lever_pos;
    logic [7:0]        ign_state;
    logic [7:0]        threshold_in;
    logic              windows_closed;
    logic              lights_on;
    logic              too_dark;
  } item_t;

  typedef struct packed {
    logic [7:0] auto_lever_code;
    logic [7:0] ign_on_code;
    logic [7:0] ign_off_code;
  } cfg_t;

  typedef struct packed {
    wmode_t wiper_mode;
    logic   rain_close_out;
  } ctrl_res_t;

endpackage

// ----- src/rain_light_sensor_wiper_mode_unit.sv -----
// Top level of the rain/light sensor wiper mode unit.
// Depends on rls_pkg, rls_light_enc and rls_wiper_ctrl.
//
// Usage:
// The input channel (in_*) carries two kinds of transaction. A demand
// (in_cmd = 0) sets the rain-driven wiper request from in_wipe_percent and
// produces no result. A tick (in_cmd = 1) runs the interval wipe timer,
// gates the wiper mode and close-windows request with the lever, ignition
// and windows values of the previous tick, encodes the ambient light level
// and produces exactly one result transaction on the out_* channel.
// The configuration channel (cfg_*) writes the lever and ignition codes by
// index; it is always ready. It is only to be written by the user while the
// unit is idle; the unit itself does not enforce this. An accepted
// transaction is held in the input register and a tick is then processed
// into the result register, from which its result is offered. Throughput is
// one transaction per cycle while the receiver does not stall, set by the
// single input register and single result register with all mode, timer
// and light logic in one combinational pass between them.
// If the receiver stalls, the result is held and the input register still
// drains demands; a tick waits in the input register, and in_ready falls
// only when both registers are occupied.
// Reset (rst_n low, synchronous) empties both registers, restores the
// configuration defaults and returns the wiper state to off.
module rain_light_sensor_wiper_mode_unit (
  input  logic              clk,
  input  logic              rst_n,
  // Input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_cmd,
  input  logic signed [7:0] in_wipe_percent,
  input  logic [31:0]       in_time_ms,
  input  logic [31:0]       in_ambient_level,
  input  logic              in_rain_close_in,
  input  logic [7:0]        in_lever_pos,
  input  logic [7:0]        in_ign_state,
  input  logic [7:0]        in_threshold_in,
  input  logic              in_windows_closed,
  input  logic              in_lights_on,
  input  logic              in_too_dark,
  // Result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_wiper_mode,
  output logic              out_rain_close_out,
  output logic [1:0]        out_light_exponent,
  output logic [6:0]        out_light_mantissa,
  output logic [1:0]        out_darkness_code,
  // Configuration channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data
);
  import rls_pkg::*;

  // Configuration registers.
  cfg_t       cfg_r, cfg_nxt;

  // Input register stage.
  logic       s1_valid_r, s1_valid_nxt;
  item_t      item_r, item_nxt;

  // Result register stage.
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] mode_out_r, mode_out_nxt;
  logic       close_out_r, close_out_nxt;
  logic [1:0] exp_out_r, exp_out_nxt;
  logic [6:0] mant_out_r, mant_out_nxt;
  logic [1:0] dark_out_r, dark_out_nxt;

  logic       in_take;
  logic       advance;
  logic       tick_done;
  ctrl_res_t  ctrl_res;
  logic [1:0] light_exp;
  logic [6:0] light_mant;
  dark_t      dark;

  // A demand leaves the input register at once; a tick needs a free
  // result register or one being drained this cycle.
  assign advance   = s1_valid_r && (item_r.cmd == CMD_DEMAND || !out_valid_r || out_ready);
  assign tick_done = advance && (item_r.cmd == CMD_TICK);
  assign in_ready  = !s1_valid_r || advance;
  assign in_take   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  rls_wiper_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (item_r),
    .cfg     (cfg_r),
    .res     (ctrl_res)
  );

  rls_light_enc u_light (
    .level    (item_r.ambient_level),
    .exponent (light_exp),
    .mantissa (light_mant)
  );

  always_comb begin
    if (item_r.lights_on) begin
      dark = item_r.too_dark ? DARK_TOO_DARK : DARK_LIGHTS;
    end else begin
      dark = DARK_OFF;
    end
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_AUTO_LEVER: cfg_nxt.auto_lever_code = cfg_data;
        REG_IGN_ON:     cfg_nxt.ign_on_code     = cfg_data;
        REG_IGN_OFF:    cfg_nxt.ign_off_code    = cfg_data;
        default:        cfg_nxt = cfg_r;
      endcase
    end

    item_nxt.cmd            = in_cmd;
    item_nxt.wipe_percent   = in_wipe_percent;
    item_nxt.time_ms        = in_time_ms;
    item_nxt.ambient_level  = in_ambient_level;
    item_nxt.rain_close_in  = in_rain_close_in;
    item_nxt.lever_pos      = in_lever_pos;
    item_nxt.ign_state      = in_ign_state;
    item_nxt.threshold_in   = in_threshold_in;
    item_nxt.windows_closed = in_windows_closed;
    item_nxt.lights_on      = in_lights_on;
    item_nxt.too_dark       = in_too_dark;
    if (!in_take) begin
      item_nxt = item_r;
    end

    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end

    mode_out_nxt  = mode_out_r;
    close_out_nxt = close_out_r;
    exp_out_nxt   = exp_out_r;
    mant_out_nxt  = mant_out_r;
    dark_out_nxt  = dark_out_r;
    if (tick_done) begin
      out_valid_nxt = 1'b1;
      mode_out_nxt  = ctrl_res.wiper_mode;
      close_out_nxt = ctrl_res.rain_close_out;
      exp_out_nxt   = light_exp;
      mant_out_nxt  = light_mant;
      dark_out_nxt  = dark;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.auto_lever_code <= AUTO_LEVER_RST;
      cfg_r.ign_on_code     <= IGN_ON_RST;
      cfg_r.ign_off_code    <= IGN_OFF_RST;
      s1_valid_r            <= 1'b0;
      out_valid_r           <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    mode_out_r  <= mode_out_nxt;
    close_out_r <= close_out_nxt;
    exp_out_r   <= exp_out_nxt;
    mant_out_r  <= mant_out_nxt;
    dark_out_r  <= dark_out_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_wiper_mode     = mode_out_r;
  assign out_rain_close_out = close_out_r;
  assign out_light_exponent = exp_out_r;
  assign out_light_mantissa = mant_out_r;
  assign out_darkness_code  = dark_out_r;

`ifndef SYNTHESIS
  // With the result register empty, the unit must always take new work.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("in_ready low while the result register is empty");

  // Every tick leaving the input register shows up as a result.
  a_tick_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    tick_done |=> out_valid_r)
    else $error("tick transaction did not produce a result");

  // A nonzero exponent means the level exceeded 127, so the mantissa is at least 12.
  a_mantissa_normalized: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_light_exponent != 2'd0) |-> (out_light_mantissa >= 7'd12))
    else $error("light mantissa not normalized for nonzero exponent");
`endif

endmodule

// ----- src/rls_light_enc.sv -----
// Ambient light encoder: decimal exponent and saturated 7-bit mantissa.
// Depends on rls_pkg.
module rls_light_enc (
  input  logic [31:0] level,
  output logic [1:0]  exponent,
  output logic [6:0]  mantissa
);
  import rls_pkg::*;

  logic [34:0] prod3;
  logic [27:0] prod2;
  logic [21:0] prod1;

  // Each quotient is only used where the level is known to fit the product.
  assign prod3 = 35'(level[16:0]) * 35'(DIV1000_MUL);
  assign prod2 = 28'(level[13:0]) * 28'(DIV100_MUL);
  assign prod1 = 22'(level[10:0]) * 22'(DIV10_MUL);

  always_comb begin
    if (level > LVL_SAT) begin
      exponent = 2'd3;
      mantissa = MANT_SAT;
    end else if (level > LVL_EXP3) begin
      exponent = 2'd3;
      mantissa = prod3[DIV1000_SH +: 7];
    end else if (level > LVL_EXP2) begin
      exponent = 2'd2;
      mantissa = prod2[DIV100_SH +: 7];
    end else if (level > LVL_EXP1) begin
      exponent = 2'd1;
      mantissa = prod1[DIV10_SH +: 7];
    end else begin
      exponent = 2'd0;
      mantissa = level[6:0];
    end
  end

endmodule

// ----- src/rls_wiper_ctrl.sv -----
// Wiper mode state: demand decoding, interval timer, lever/ignition gating.
// Depends on rls_pkg.
module rls_wiper_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  rls_pkg::item_t    item,
  input  rls_pkg::cfg_t     cfg,
  output rls_pkg::ctrl_res_t res
);
  import rls_pkg::*;

  wmode_t            mode_r, mode_nxt;
  logic [12:0]       period_r, period_nxt;
  logic [31:0]       start_r, start_nxt;
  logic              running_r, running_nxt;
  logic [7:0]        last_lever_r, last_lever_nxt;
  logic [7:0]        last_ign_r, last_ign_nxt;
  logic [THR_W-1:0]  last_thr_r, last_thr_nxt;
  logic              last_wc_r, last_wc_nxt;

  logic [6:0]        pct;
  logic [5:0]        pct_x15;
  logic [12:0]       demand_period;
  logic [31:0]       start_eff;
  logic [31:0]       elapsed;
  logic [31:0]       deadline;
  wmode_t            mode_tick;
  wmode_t            out_mode;
  logic [THR_W-1:0]  thr;
  logic              close_req;

  always_comb begin
    // Clamp the signed demand to 0..100.
    if (item.wipe_percent[7]) begin
      pct = 7'd0;
    end else if (item.wipe_percent[6:0] > PCT_MAX) begin
      pct = PCT_MAX;
    end else begin
      pct = item.wipe_percent[6:0];
    end
    // percent * 15 / 10 is floor(1.5 * percent); only used for 5..40.
    pct_x15 = 6'(pct) + 6'(pct >> 1);
    demand_period = INTERVAL_BASE - 13'(pct_x15) * 13'(INTERVAL_STEP);

    // Interval timer restarts at the tick time when it is not running.
    start_eff = running_r ? start_r : item.time_ms;
    elapsed   = item.time_ms - start_eff;
    deadline  = start_eff + 32'(period_r);

    mode_tick   = mode_r;
    start_nxt   = start_r;
    running_nxt = running_r;
    if (period_r != 13'd0) begin
      start_nxt   = start_eff;
      running_nxt = !(item.time_ms > deadline);
      mode_tick   = (elapsed < ONCE_WINDOW) ? MODE_ONCE : MODE_OFF;
    end
    // Lever out of auto or ignition off on the previous tick clears the mode.
    if (last_lever_r != cfg.auto_lever_code || last_ign_r != cfg.ign_on_code) begin
      mode_tick = MODE_OFF;
    end

    close_req = item.rain_close_in && (last_ign_r == cfg.ign_off_code) && !last_wc_r;

    thr = (item.threshold_in > THR_MAX) ? THR_W'(THR_MAX) : THR_W'(item.threshold_in);

    // A lever or sensitivity change in auto with the wiper idle wipes once.
    out_mode = mode_tick;
    if ((item.lever_pos != last_lever_r || thr != last_thr_r) &&
        item.lever_pos == cfg.auto_lever_code && item.ign_state == cfg.ign_on_code &&
        mode_tick == MODE_OFF) begin
      out_mode = MODE_ONCE;
    end

    mode_nxt       = mode_r;
    period_nxt     = period_r;
    last_lever_nxt = last_lever_r;
    last_ign_nxt   = last_ign_r;
    last_thr_nxt   = last_thr_r;
    last_wc_nxt    = last_wc_r;
    if (step_en) begin
      if (item.cmd == CMD_DEMAND) begin
        period_nxt = 13'd0;
        start_nxt   = start_r;
        running_nxt = running_r;
        if (pct > PCT_FAST) begin
          mode_nxt = MODE_FAST;
        end else if (pct > PCT_SLOW) begin
          mode_nxt = MODE_SLOW;
        end else if (pct >= PCT_INT_MIN) begin
          period_nxt = demand_period;
        end else begin
          mode_nxt = MODE_OFF;
        end
      end else begin
        mode_nxt       = mode_tick;
        last_lever_nxt = item.lever_pos;
        last_ign_nxt   = item.ign_state;
        last_thr_nxt   = thr;
        last_wc_nxt    = item.windows_closed;
      end
    end else begin
      start_nxt   = start_r;
      running_nxt = running_r;
    end

    res.wiper_mode     = out_mode;
    res.rain_close_out = close_req;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_OFF;
      period_r     <= 13'd0;
      start_r      <= 32'd0;
      running_r    <= 1'b0;
      last_lever_r <= LEVER_OFF_CODE;
      last_ign_r   <= IGN_ON_RST;
      last_thr_r   <= '0;
      last_wc_r    <= 1'b0;
    end else begin
      mode_r       <= mode_nxt;
      period_r     <= period_nxt;
      start_r      <= start_nxt;
      running_r    <= running_nxt;
      last_lever_r <= last_lever_nxt;
      last_ign_r   <= last_ign_nxt;
      last_thr_r   <= last_thr_nxt;
      last_wc_r    <= last_wc_nxt;
    end
  end

endmodule
